/* design/tank_fill_pump_controller_assert.svh */
// Assertion macros shared by the pump controller RTL.
`ifndef TANK_FILL_PUMP_CONTROLLER_ASSERT_SVH
`define TANK_FILL_PUMP_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TFPC_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfpc: check failed");

// Next-cycle implication, checked out of reset.
`define TFPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfpc: check failed");

`endif

/* design/tfpc_pkg.sv */
// Types, widths, register map and reset values of the tank fill pump controller.
`timescale 1ns / 1ps

package tfpc_pkg;

  localparam int MODE_W  = 2;
  localparam int FILT_W  = 16;
  localparam int FCNT_W  = FILT_W + 1;
  localparam int CFG_T_W = 24;
  localparam int TIMER_WIDTH_DEF = 24;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_AUTO      = 2'd0,
    MODE_MANUAL    = 2'd1,
    MODE_MAINT     = 2'd2,
    MODE_FORCE_OFF = 2'd3
  } mode_t;

  localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_FILTER  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_RUN = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_OFF = 3'd3;
  localparam logic [IDX_W-1:0] REG_FINISH  = 3'd4;

  localparam mode_t              MODE_RST    = MODE_AUTO;
  localparam logic [FILT_W-1:0]  FILTER_RST  = 16'd3000;
  localparam logic [CFG_T_W-1:0] MAX_RUN_RST = 24'd900000;
  localparam logic [CFG_T_W-1:0] MIN_OFF_RST = 24'd30000;
  localparam logic [CFG_T_W-1:0] FINISH_RST  = 24'd60000;

  typedef struct packed {
    logic low_switch_raw;
    logic high_switch_raw;
    logic stop_pressed;
    logic start_pressed;
    logic emergency_stop;
  } item_t;

  typedef struct packed {
    logic pump_on;
    logic fault_latched;
    logic sensors_incoherent;
    logic high_level_filtered;
    logic low_level_filtered;
    logic manual_run_active;
    logic finishing_active;
    logic pump_started;
    logic pump_stopped;
  } result_t;

endpackage

/* design/tank_fill_pump_controller.sv */
// Tank fill pump controller: level switch filters, run/off timers and pump decision.
// An item's result is computed as it leaves the input register and is held in the result
// register until it is transferred out.
// Throughput: one item per clock while the result channel does not stall; the filter and
// pump state update in the single pass between the input register and the result register.
// Reset (rst, synchronous): pump off, fault, latches and counters cleared, filtered levels
// high, configuration registers back to their defaults, both registers empty.
`timescale 1ns / 1ps
`include "tank_fill_pump_controller_assert.svh"

module tank_fill_pump_controller #(
  parameter int TIMER_WIDTH = tfpc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // item channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       low_switch_raw,
  input  logic                       high_switch_raw,
  input  logic                       stop_pressed,
  input  logic                       start_pressed,
  input  logic                       emergency_stop,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       pump_on,
  output logic                       fault_latched,
  output logic                       sensors_incoherent,
  output logic                       high_level_filtered,
  output logic                       low_level_filtered,
  output logic                       manual_run_active,
  output logic                       finishing_active,
  output logic                       pump_started,
  output logic                       pump_stopped,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tfpc_pkg::ADDR_W-1:0] paddr,
  input  logic [tfpc_pkg::DATA_W-1:0] pwdata,
  output logic [tfpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CMP_W = (TIMER_WIDTH > tfpc_pkg::CFG_T_W) ? TIMER_WIDTH : tfpc_pkg::CFG_T_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  // configuration registers
  tfpc_pkg::mode_t                  mode;
  logic [tfpc_pkg::FILT_W-1:0]      filter_ticks;
  logic [tfpc_pkg::CFG_T_W-1:0]     max_run_ticks;
  logic [tfpc_pkg::CFG_T_W-1:0]     min_off_ticks;
  logic [tfpc_pkg::CFG_T_W-1:0]     finish_ticks;

  logic                         cfg_wr;
  logic [tfpc_pkg::IDX_W-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[tfpc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= tfpc_pkg::MODE_RST;
      filter_ticks  <= tfpc_pkg::FILTER_RST;
      max_run_ticks <= tfpc_pkg::MAX_RUN_RST;
      min_off_ticks <= tfpc_pkg::MIN_OFF_RST;
      finish_ticks  <= tfpc_pkg::FINISH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tfpc_pkg::REG_MODE:    mode <= tfpc_pkg::mode_t'(pwdata[tfpc_pkg::MODE_W-1:0]);
        tfpc_pkg::REG_FILTER:  filter_ticks <= pwdata[tfpc_pkg::FILT_W-1:0];
        tfpc_pkg::REG_MAX_RUN: max_run_ticks <= pwdata[tfpc_pkg::CFG_T_W-1:0];
        tfpc_pkg::REG_MIN_OFF: min_off_ticks <= pwdata[tfpc_pkg::CFG_T_W-1:0];
        tfpc_pkg::REG_FINISH:  finish_ticks <= pwdata[tfpc_pkg::CFG_T_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tfpc_pkg::REG_MODE:    prdata = tfpc_pkg::DATA_W'(mode);
      tfpc_pkg::REG_FILTER:  prdata = tfpc_pkg::DATA_W'(filter_ticks);
      tfpc_pkg::REG_MAX_RUN: prdata = tfpc_pkg::DATA_W'(max_run_ticks);
      tfpc_pkg::REG_MIN_OFF: prdata = tfpc_pkg::DATA_W'(min_off_ticks);
      tfpc_pkg::REG_FINISH:  prdata = tfpc_pkg::DATA_W'(finish_ticks);
      default:               prdata = '0;
    endcase
  end

  // input register and result register handshake
  logic               s1_valid;
  tfpc_pkg::item_t    s1;
  tfpc_pkg::result_t  res;
  tfpc_pkg::result_t  res_next;
  logic               out_free;
  logic               adv;

  assign out_free = !out_valid || !out_stall;
  assign adv      = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1.low_switch_raw  <= low_switch_raw;
      s1.high_switch_raw <= high_switch_raw;
      s1.stop_pressed    <= stop_pressed;
      s1.start_pressed   <= start_pressed;
      s1.emergency_stop  <= emergency_stop;
    end
    if (adv) begin
      res <= res_next;
    end
  end

  // controller state
  logic                          relay, fault, manual, fin, hs, ls;
  logic [tfpc_pkg::FCNT_W-1:0]   hcnt, lcnt;
  logic [tfpc_pkg::CFG_T_W-1:0]  run;
  logic [TIMER_WIDTH-1:0]        off, fcnt;

  logic                          relay_next, fault_next, manual_next, fin_next;
  logic                          hs_next, ls_next;
  logic [tfpc_pkg::FCNT_W-1:0]   hcnt_next, lcnt_next;
  logic [tfpc_pkg::CFG_T_W-1:0]  run_next;
  logic [TIMER_WIDTH-1:0]        off_next, fcnt_next;
  logic                          incoherent, run_fault, req_on, req_off;
  logic                          ev_start, ev_stop;
  logic [tfpc_pkg::FCNT_W-1:0]   filt_lim;

  assign filt_lim = tfpc_pkg::FCNT_W'(filter_ticks);

  always_comb begin
    relay_next  = relay;
    fault_next  = fault;
    manual_next = manual;
    fin_next    = fin;
    hs_next     = hs;
    ls_next     = ls;
    hcnt_next   = hcnt;
    lcnt_next   = lcnt;
    run_next    = run;
    off_next    = off;
    fcnt_next   = fcnt;
    run_fault   = 1'b0;
    req_on      = 1'b0;
    req_off     = 1'b0;
    ev_start    = 1'b0;
    ev_stop     = 1'b0;

    // saturating timers
    if (!relay && off != TIMER_MAX) off_next = off + 1'b1;
    if (fin && fcnt != TIMER_MAX) fcnt_next = fcnt + 1'b1;

    // level filters: an active reading must outlast the filter delay
    if (!s1.high_switch_raw && hs) begin
      if (hcnt == '0) begin
        hcnt_next = tfpc_pkg::FCNT_W'(1);
      end else if (hcnt > filt_lim) begin
        hs_next   = 1'b0;
        hcnt_next = '0;
      end else begin
        hcnt_next = hcnt + 1'b1;
      end
    end else if (s1.high_switch_raw) begin
      hs_next   = 1'b1;
      hcnt_next = '0;
    end

    if (!s1.low_switch_raw && ls) begin
      if (lcnt == '0) begin
        lcnt_next = tfpc_pkg::FCNT_W'(1);
      end else if (lcnt > filt_lim) begin
        ls_next   = 1'b0;
        lcnt_next = '0;
      end else begin
        lcnt_next = lcnt + 1'b1;
      end
    end else if (s1.low_switch_raw) begin
      ls_next   = 1'b1;
      lcnt_next = '0;
    end

    incoherent = !hs_next && ls_next;

    if (relay) begin
      if (run >= max_run_ticks) run_fault = 1'b1;
      else run_next = run + 1'b1;
    end

    if (s1.emergency_stop || fault) begin
      req_off     = 1'b1;
      manual_next = 1'b0;
      fin_next    = 1'b0;
    end else if (run_fault) begin
      fault_next  = 1'b1;
      req_off     = 1'b1;
      manual_next = 1'b0;
      fin_next    = 1'b0;
    end else begin
      case (mode)
        tfpc_pkg::MODE_AUTO: begin
          if (incoherent) begin
            req_off  = 1'b1;
            fin_next = 1'b0;
          end else if (!hs_next) begin
            // full: start or continue the finishing period
            if (!fin) begin
              fin_next  = 1'b1;
              fcnt_next = '0;
              req_on    = 1'b1;
            end else if (CMP_W'(fcnt_next) < CMP_W'(finish_ticks)) begin
              req_on = 1'b1;
            end else begin
              req_off = 1'b1;
            end
          end else begin
            fin_next = 1'b0;
            if (ls_next) req_on = 1'b1;
          end
        end
        tfpc_pkg::MODE_MANUAL: begin
          if (s1.stop_pressed || !hs_next) begin
            req_off     = 1'b1;
            manual_next = 1'b0;
            fin_next    = 1'b0;
          end else begin
            fin_next = 1'b0;
            if (s1.start_pressed || manual) begin
              manual_next = 1'b1;
              req_on      = 1'b1;
            end else begin
              req_off = 1'b1;
            end
          end
        end
        tfpc_pkg::MODE_MAINT: begin
          req_off     = 1'b1;
          manual_next = 1'b0;
        end
        default: req_off = 1'b1;
      endcase
    end

    // apply the pump request; a start waits out the minimum off time
    if (req_on) begin
      if (!fault_next && CMP_W'(off_next) >= CMP_W'(min_off_ticks) && !relay) begin
        relay_next = 1'b1;
        run_next   = '0;
        ev_start   = 1'b1;
      end
    end else if (req_off && relay) begin
      relay_next = 1'b0;
      off_next   = '0;
      ev_stop    = 1'b1;
    end

    res_next.pump_on             = relay_next;
    res_next.fault_latched       = fault_next;
    res_next.sensors_incoherent  = incoherent;
    res_next.high_level_filtered = hs_next;
    res_next.low_level_filtered  = ls_next;
    res_next.manual_run_active   = manual_next;
    res_next.finishing_active    = fin_next;
    res_next.pump_started        = ev_start;
    res_next.pump_stopped        = ev_stop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay  <= 1'b0;
      fault  <= 1'b0;
      manual <= 1'b0;
      fin    <= 1'b0;
      hs     <= 1'b1;
      ls     <= 1'b1;
      hcnt   <= '0;
      lcnt   <= '0;
      run    <= '0;
      off    <= '0;
      fcnt   <= '0;
    end else if (adv) begin
      relay  <= relay_next;
      fault  <= fault_next;
      manual <= manual_next;
      fin    <= fin_next;
      hs     <= hs_next;
      ls     <= ls_next;
      hcnt   <= hcnt_next;
      lcnt   <= lcnt_next;
      run    <= run_next;
      off    <= off_next;
      fcnt   <= fcnt_next;
    end
  end

  assign pump_on             = res.pump_on;
  assign fault_latched       = res.fault_latched;
  assign sensors_incoherent  = res.sensors_incoherent;
  assign high_level_filtered = res.high_level_filtered;
  assign low_level_filtered  = res.low_level_filtered;
  assign manual_run_active   = res.manual_run_active;
  assign finishing_active    = res.finishing_active;
  assign pump_started        = res.pump_started;
  assign pump_stopped        = res.pump_stopped;

  `TFPC_ASSERT_NEXT(a_fault_sticky, clk, rst, fault, fault)
  `TFPC_ASSERT_NOW(a_fault_pump_off, clk, rst, fault, !relay)
  `TFPC_ASSERT_NEXT(a_state_holds, clk, rst, !adv, $stable(relay) && $stable(off))
  `TFPC_ASSERT_NOW(a_start_runs, clk, rst, out_valid && pump_started, pump_on && !pump_stopped)

endmodule
